>>> rtl/core/bfba_pkg.sv
`default_nettype none

package bfba_pkg;

  localparam int BLOCK_BYTES_DEF    = 4096;
  localparam int MAX_MAP_BLOCKS_DEF = 4;

  localparam int CMD_W     = 2;
  localparam int INDEX_W   = 14;
  localparam int BYTE_W    = 8;
  localparam int BLKNUM_W  = 18;
  localparam int DIRTY_W   = 4;
  localparam int CFG_W     = 3;

  localparam logic [BYTE_W-1:0] BYTE_FULL = 8'hff;
  localparam logic [BYTE_W-1:0] BIT_FIRST = 8'h80;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_ALLOC = 2'd1,
    CMD_READ  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_DONE
  } state_t;

  function automatic logic [2:0] first_clear_bit(input logic [BYTE_W-1:0] b);
    logic [2:0] pos;
    pos = 3'd0;
    for (int i = 0; i < BYTE_W; i++) begin
      if (!b[i]) begin
        pos = 3'(BYTE_W - 1 - i);
      end
    end
    return pos;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/bfba_ram.sv
`default_nettype none

module bfba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16384,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/core/bitmap_free_block_allocator.sv
`default_nettype none

// Bitmap free-block allocator. Software loads the allocation bitmap one byte per
// beat, then allocate commands return the first clear bit (MSB first) of the map
// blocks in use, set it and mark its map block dirty; read and clear-dirty support
// write-back. The bitmap lives in one byte-wide RAM with one read and one write
// port, and allocation streams through it one byte per cycle, scanning the map
// blocks in use (used_map_blocks capped at MAX_MAP_BLOCKS) until the first
// non-full byte or the end of the map. Load and clear-dirty go straight to the
// done state; read passes through a read state first. One command is in flight at a
// time; a finished result waits in the output register while the next command is
// accepted. Bytes never loaded read as undefined.

module bitmap_free_block_allocator #(
  parameter int BLOCK_BYTES    = bfba_pkg::BLOCK_BYTES_DEF,
  parameter int MAX_MAP_BLOCKS = bfba_pkg::MAX_MAP_BLOCKS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,

  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [bfba_pkg::CMD_W-1:0]    in_command,
  input  wire logic [bfba_pkg::INDEX_W-1:0]  in_byte_index,
  input  wire logic [bfba_pkg::BYTE_W-1:0]   in_byte_value,

  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [bfba_pkg::BLKNUM_W-1:0]      out_block_number,
  output logic [bfba_pkg::BYTE_W-1:0]        out_read_value,
  output logic                               out_status,
  output logic [bfba_pkg::DIRTY_W-1:0]       out_dirty_mask,

  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [bfba_pkg::CFG_W-1:0]    cfg_used_map_blocks
);

  localparam int STORE = BLOCK_BYTES * MAX_MAP_BLOCKS;
  localparam int AW    = (STORE > 1) ? $clog2(STORE) : 1;
  localparam int XW    = ((AW > bfba_pkg::INDEX_W) ? AW : bfba_pkg::INDEX_W) + 1;
  localparam int OW    = $clog2(BLOCK_BYTES);
  localparam int BW    = (MAX_MAP_BLOCKS > 1) ? $clog2(MAX_MAP_BLOCKS) : 1;
  localparam int CW    = (bfba_pkg::CFG_W > BW + 1) ? bfba_pkg::CFG_W + 1 : BW + 2;
  localparam int NW    = AW + 4;
  localparam int DW    = (MAX_MAP_BLOCKS > bfba_pkg::DIRTY_W) ? MAX_MAP_BLOCKS
                                                            : bfba_pkg::DIRTY_W;

  bfba_pkg::state_t state_r, state_nxt;
  bfba_pkg::cmd_t   cmd;

  logic [bfba_pkg::CFG_W-1:0]    cfg_blocks_r;
  logic [MAX_MAP_BLOCKS-1:0]     dirty_r, dirty_nxt;
  logic [AW:0]                   issue_addr_r, issue_addr_nxt;
  logic [OW-1:0]                 issue_off_r, issue_off_nxt;
  logic [BW-1:0]                 issue_blk_r, issue_blk_nxt;
  logic                          pend_v_r, pend_v_nxt;
  logic [AW-1:0]                 pend_addr_r, pend_addr_nxt;
  logic [BW-1:0]                 pend_blk_r, pend_blk_nxt;
  logic [AW:0]                   limit_r, limit_nxt;
  logic                          rd_ok_r, rd_ok_nxt;
  logic [bfba_pkg::BLKNUM_W-1:0] res_block_r, res_block_nxt;
  logic [bfba_pkg::BYTE_W-1:0]   res_read_r, res_read_nxt;
  logic                          res_status_r, res_status_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [bfba_pkg::BLKNUM_W-1:0] out_block_r;
  logic [bfba_pkg::BYTE_W-1:0]   out_read_r;
  logic                          out_status_r;
  logic [bfba_pkg::DIRTY_W-1:0]  out_dirty_r;

  logic                          accept;
  logic                          out_load;
  logic [XW-1:0]                 idx_x;
  logic                          in_range;
  logic [CW-1:0]                 blocks_sat;
  logic                          issue_ok;
  logic                          hit;
  logic [2:0]                    hit_bit;
  logic [NW-1:0]                 hit_num;
  logic [DW-1:0]                 dirty_x;

  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr;
  logic [bfba_pkg::BYTE_W-1:0]   ram_wdata;
  logic [AW-1:0]                 ram_raddr;
  logic [bfba_pkg::BYTE_W-1:0]   ram_rdata;

  bfba_ram #(
    .WIDTH (bfba_pkg::BYTE_W),
    .DEPTH (STORE)
  ) u_bitmap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_stall  = (state_r != bfba_pkg::ST_IDLE);
  assign cfg_ready = (state_r == bfba_pkg::ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign cmd       = bfba_pkg::cmd_t'(in_command);
  assign out_load  = (state_r == bfba_pkg::ST_DONE) && (!out_valid_r || !out_stall);

  assign idx_x    = XW'(in_byte_index);
  assign in_range = idx_x < XW'(STORE);

  assign blocks_sat = (CW'(cfg_blocks_r) > CW'(MAX_MAP_BLOCKS)) ? CW'(MAX_MAP_BLOCKS)
                                                              : CW'(cfg_blocks_r);
  assign issue_ok = issue_addr_r < limit_r;
  assign hit      = pend_v_r && (ram_rdata != bfba_pkg::BYTE_FULL);
  assign hit_bit  = bfba_pkg::first_clear_bit(ram_rdata);
  assign hit_num  = NW'({pend_addr_r, hit_bit}) + NW'(1);
  assign dirty_x  = DW'(dirty_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bfba_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (cmd)
            bfba_pkg::CMD_ALLOC: state_nxt = bfba_pkg::ST_SCAN;
            bfba_pkg::CMD_READ:  state_nxt = bfba_pkg::ST_READ;
            default:             state_nxt = bfba_pkg::ST_DONE;
          endcase
        end
      end
      bfba_pkg::ST_READ: state_nxt = bfba_pkg::ST_DONE;
      bfba_pkg::ST_SCAN: begin
        if (hit || (!pend_v_r && !issue_ok)) begin
          state_nxt = bfba_pkg::ST_DONE;
        end
      end
      bfba_pkg::ST_DONE: begin
        if (out_load) begin
          state_nxt = bfba_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bfba_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    dirty_nxt      = dirty_r;
    issue_addr_nxt = issue_addr_r;
    issue_off_nxt  = issue_off_r;
    issue_blk_nxt  = issue_blk_r;
    pend_v_nxt     = 1'b0;
    pend_addr_nxt  = pend_addr_r;
    pend_blk_nxt   = pend_blk_r;
    limit_nxt      = limit_r;
    rd_ok_nxt      = rd_ok_r;
    res_block_nxt  = res_block_r;
    res_read_nxt   = res_read_r;
    res_status_nxt = res_status_r;
    ram_we         = 1'b0;
    ram_waddr      = idx_x[AW-1:0];
    ram_wdata      = in_byte_value;
    ram_raddr      = idx_x[AW-1:0];

    unique case (state_r)
      bfba_pkg::ST_IDLE: begin
        if (accept) begin
          res_block_nxt  = '0;
          res_read_nxt   = '0;
          res_status_nxt = 1'b0;
          rd_ok_nxt      = in_range;
          issue_addr_nxt = '0;
          issue_off_nxt  = '0;
          issue_blk_nxt  = '0;
          limit_nxt      = (AW + 1)'(blocks_sat * BLOCK_BYTES);
          unique case (cmd)
            bfba_pkg::CMD_LOAD:  ram_we    = in_range;
            bfba_pkg::CMD_CLEAR: dirty_nxt = '0;
            default: ;
          endcase
        end
      end
      bfba_pkg::ST_READ: begin
        res_read_nxt = rd_ok_r ? ram_rdata : '0;
      end
      bfba_pkg::ST_SCAN: begin
        ram_raddr = issue_addr_r[AW-1:0];
        if (hit) begin
          ram_we                 = 1'b1;
          ram_waddr              = pend_addr_r;
          ram_wdata              = ram_rdata | (bfba_pkg::BIT_FIRST >> hit_bit);
          dirty_nxt[pend_blk_r]  = 1'b1;
          res_block_nxt          = bfba_pkg::BLKNUM_W'(hit_num);
        end else if (!pend_v_r && !issue_ok) begin
          res_status_nxt = 1'b1;
        end else if (issue_ok) begin
          pend_v_nxt     = 1'b1;
          pend_addr_nxt  = issue_addr_r[AW-1:0];
          pend_blk_nxt   = issue_blk_r;
          issue_addr_nxt = issue_addr_r + (AW + 1)'(1);
          if (issue_off_r == OW'(BLOCK_BYTES - 1)) begin
            issue_off_nxt = '0;
            issue_blk_nxt = issue_blk_r + BW'(1);
          end else begin
            issue_off_nxt = issue_off_r + OW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= bfba_pkg::ST_IDLE;
      cfg_blocks_r <= bfba_pkg::CFG_W'(1);
      dirty_r      <= '0;
      pend_v_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dirty_r     <= dirty_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        cfg_blocks_r <= cfg_used_map_blocks;
      end
    end
  end

  always_ff @(posedge clk) begin
    issue_addr_r <= issue_addr_nxt;
    issue_off_r  <= issue_off_nxt;
    issue_blk_r  <= issue_blk_nxt;
    pend_addr_r  <= pend_addr_nxt;
    pend_blk_r   <= pend_blk_nxt;
    limit_r      <= limit_nxt;
    rd_ok_r      <= rd_ok_nxt;
    res_block_r  <= res_block_nxt;
    res_read_r   <= res_read_nxt;
    res_status_r <= res_status_nxt;
    if (out_load) begin
      out_block_r  <= res_block_r;
      out_read_r   <= res_read_r;
      out_status_r <= res_status_r;
      out_dirty_r  <= dirty_x[bfba_pkg::DIRTY_W-1:0];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_block_number = out_block_r;
  assign out_read_value   = out_read_r;
  assign out_status       = out_status_r;
  assign out_dirty_mask   = out_dirty_r;

endmodule

`default_nettype wire
